// ===== design/crc16_frame_receive_checker_top_defines.svh =====
// Assertion macros shared by the checker RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef CRC16_FRAME_RECEIVE_CHECKER_TOP_DEFINES_SVH
`define CRC16_FRAME_RECEIVE_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define CRC16FR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define CRC16FR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/crc16fr_pkg.sv =====
`timescale 1ns / 1ps

package crc16fr_pkg;

	localparam logic [15:0] CRC_POLY        = 16'h1021;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4090;

	// Byte position counter: saturates at its all-ones value.
	localparam int unsigned POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX       = '1;
	localparam logic [POS_W-1:0] HDR_BYTES     = 17'd4;
	localparam logic [POS_W-1:0] FRAME_OVERHEAD = 17'd6;

	typedef enum logic [2:0] {
		VERD_OK    = 3'd0,
		VERD_SHORT = 3'd1,
		VERD_LEN   = 3'd2,
		VERD_COUNT = 3'd3,
		VERD_CRC   = 3'd4
	} verdict_t;

	// Register index, taken from the word-address bit of paddr.
	typedef enum logic {
		REG_MAX_PAYLOAD = 1'b0
	} reg_index_t;

	// One byte of CRC-16/XMODEM, MSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== design/crc16fr_apb_regs.sv =====
`timescale 1ns / 1ps

module crc16fr_apb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] max_payload
);
	import crc16fr_pkg::*;

	reg_index_t  idx;
	logic        wr_en;
	logic [15:0] max_payload_q;

	assign idx    = reg_index_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (wr_en && idx == REG_MAX_PAYLOAD) begin
			max_payload_q <= pwdata[15:0];
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAX_PAYLOAD: prdata = {16'h0000, max_payload_q};
			default:         prdata = '0;
		endcase
	end

	assign max_payload = max_payload_q;

endmodule

// ===== design/crc16_frame_receive_checker_top.sv =====
`timescale 1ns / 1ps
// A beat goes from the input stage into the result register, which drives out_valid.
// Throughput: one beat per cycle while not stalled; the byte-wide CRC update and the
// frame checks run in a single pass between the input stage and the result register.
// Reset: arst_n clears all frame state and valids and sets max_payload to 4090.

module crc16_frame_receive_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_transfer,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_verdict,
	output logic [7:0]  payload_byte,
	output logic [15:0] frame_command,
	output logic [15:0] frame_length,
	output logic [2:0]  verdict,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import crc16fr_pkg::*;
	`include "crc16_frame_receive_checker_top_defines.svh"

	logic [15:0] max_payload;

	// The register block holds the payload length limit.
	crc16fr_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.max_payload (max_payload)
	);

	// Input stage: one beat waits here until the result register can take it.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;

	// Frame state.
	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [15:0]      cmd_q;
	logic [15:0]      len_q;
	logic [15:0]      rcrc_q;
	logic             len_err_q;

	// Result register.
	logic        out_valid_q;
	logic        is_verdict_q;
	logic [7:0]  payload_byte_q;
	logic [15:0] frame_command_q;
	logic [15:0] frame_length_q;
	verdict_t    verdict_q;

	// Next-state and result logic for the beat in the input stage.
	logic             in_hdr;
	logic             in_payload;
	logic [POS_W-1:0] count;
	logic [15:0]      crc_upd;
	logic [15:0]      cmd_n;
	logic [15:0]      len_n;
	logic [15:0]      crc_n;
	logic [15:0]      rcrc_n;
	logic             len_err_n;
	logic             short_frame;
	verdict_t         verdict_n;
	logic             has_result;
	logic             out_free;
	logic             advance;

	always_comb begin
		// The first four bytes are the header; the next len_q bytes are payload and
		// everything after that shifts into the received CRC.
		in_hdr     = pos_q < HDR_BYTES;
		in_payload = !in_hdr && (pos_q < ({1'b0, len_q} + HDR_BYTES));
		crc_upd    = crc16_byte(crc_q, byte_s1);

		cmd_n  = (pos_q[POS_W-1:1] == '0) ? {cmd_q[7:0], byte_s1} : cmd_q;
		len_n  = (in_hdr && pos_q[1]) ? {len_q[7:0], byte_s1} : len_q;
		crc_n  = (in_hdr || in_payload) ? crc_upd : crc_q;
		rcrc_n = (!in_hdr && !in_payload) ? {rcrc_q[7:0], byte_s1} : rcrc_q;

		// The length check is latched once the header completes, so a later
		// register write cannot change the verdict of this frame.
		len_err_n = (pos_q == HDR_BYTES - 17'd1) ? (len_n > max_payload) : len_err_q;

		count = (pos_q == POS_MAX) ? pos_q : pos_q + 17'd1;

		// Verdict precedence: short, length, count, CRC.
		short_frame = count < HDR_BYTES;
		if (short_frame) begin
			verdict_n = VERD_SHORT;
		end else if (len_err_n) begin
			verdict_n = VERD_LEN;
		end else if (count != ({1'b0, len_n} + FRAME_OVERHEAD)) begin
			verdict_n = VERD_COUNT;
		end else if (rcrc_n != crc_n) begin
			verdict_n = VERD_CRC;
		end else begin
			verdict_n = VERD_OK;
		end

		// The flagged beat always gives a verdict; other payload beats pass on
		// unless the frame length was refused.
		has_result = eot_s1 || (in_payload && !len_err_n);
	end

	// A beat that gives no result never waits for the result register.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (out_free || !has_result);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
			eot_s1  <= end_of_transfer;
		end
	end

	// Frame state returns to zero after each verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= '0;
			cmd_q     <= '0;
			len_q     <= '0;
			rcrc_q    <= '0;
			len_err_q <= 1'b0;
		end else if (advance) begin
			if (eot_s1) begin
				pos_q     <= '0;
				crc_q     <= '0;
				cmd_q     <= '0;
				len_q     <= '0;
				rcrc_q    <= '0;
				len_err_q <= 1'b0;
			end else begin
				pos_q     <= count;
				crc_q     <= crc_n;
				cmd_q     <= cmd_n;
				len_q     <= len_n;
				rcrc_q    <= rcrc_n;
				len_err_q <= len_err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_result;
		end
	end

	// In a short-frame verdict the header fields read as zero.
	always_ff @(posedge clk) begin
		if (out_free && advance && has_result) begin
			is_verdict_q    <= eot_s1;
			payload_byte_q  <= eot_s1 ? 8'h00 : byte_s1;
			frame_command_q <= (eot_s1 && short_frame) ? 16'h0000 : cmd_n;
			frame_length_q  <= (eot_s1 && short_frame) ? 16'h0000 : len_n;
			verdict_q       <= eot_s1 ? verdict_n : VERD_OK;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_verdict    = is_verdict_q;
	assign payload_byte  = payload_byte_q;
	assign frame_command = frame_command_q;
	assign frame_length  = frame_length_q;
	assign verdict       = verdict_q;

	`CRC16FR_ASSERT_NEXT(a_pos_clears, advance && eot_s1, pos_q == '0,
		"byte position not cleared after a verdict")
	`CRC16FR_ASSERT_IMPL(a_verdict_no_byte, out_valid_q && is_verdict_q,
		payload_byte_q == 8'h00, "verdict beat carries a payload byte")
	`CRC16FR_ASSERT_IMPL(a_payload_ok, out_valid_q && !is_verdict_q,
		verdict_q == VERD_OK, "payload beat carries a verdict code")
	`CRC16FR_ASSERT_IMPL(a_short_no_hdr, out_valid_q && verdict_q == VERD_SHORT,
		frame_command_q == 16'h0000 && frame_length_q == 16'h0000,
		"short-frame verdict carries header fields")

endmodule

// ===== tb/tb_crc16_frame_receive_checker_top.sv =====
`timescale 1ns / 1ps

module tb_crc16_frame_receive_checker_top;
	import crc16fr_pkg::*;

	// Register addresses: the register index sits in bit 2 of paddr.
	localparam logic [2:0] ADDR_MAX_PAYLOAD = 3'd0;
	localparam logic [2:0] ADDR_UNUSED      = 3'd4;

	// Cycles allowed after the last expected result before the block counts as idle.
	// A payload beat of an over-long frame yields nothing, so it can still be in flight.
	localparam int DRAIN_PAD = 8;
	// Length of the deliberate receiver hold-off that backs the pipeline up.
	localparam int LONG_HOLD = 200;
	// Cycles with no beat moving on either channel before the run is abandoned.
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} rx_beat_t;

	typedef struct packed {
		logic        is_verdict;
		logic [7:0]  payload_byte;
		logic [15:0] frame_command;
		logic [15:0] frame_length;
		verdict_t    verdict;
	} frame_result_t;

	// Shapes of transfer the stimulus generator can build.
	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_TRUNC,
		FR_EXTRA,
		FR_SHORT,
		FR_LONG,
		FR_NOISE
	} frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        end_of_transfer = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        is_verdict;
	logic [7:0]  payload_byte;
	logic [15:0] frame_command;
	logic [15:0] frame_length;
	logic [2:0]  verdict;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	crc16_frame_receive_checker_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.end_of_transfer(end_of_transfer),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.is_verdict     (is_verdict),
		.payload_byte   (payload_byte),
		.frame_command  (frame_command),
		.frame_length   (frame_length),
		.verdict        (verdict),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #1 clk = ~clk;

	// Beats waiting to be offered, and results the frame checker owes us.
	rx_beat_t      beats_to_send[$];
	frame_result_t expected_results[$];
	int unsigned   beats_queued = 0;
	int unsigned   mismatches = 0;

	// Idle and stall rates in percent, set per phase by the sequencer.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// The sequencer bumps hold_req; the receiver notices and runs its own hold-off count.
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int idle_cycles = 0;

	// Predictor state: a private copy of the frame tracking and of the length limit.
	logic [16:0] pred_pos;
	logic [15:0] pred_crc;
	logic [15:0] pred_cmd;
	logic [15:0] pred_len;
	logic [15:0] pred_rx_crc;
	logic        pred_len_err;
	logic [15:0] pred_max;

	// CRC-16/XMODEM, one byte, computed bit-serially from the top bit down.
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int k = 7; k >= 0; k--) begin
			fb = crc[15] ^ b[k];
			crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return crc;
	endfunction

	task automatic clear_prediction();
		pred_pos = '0;
		pred_crc = '0;
		pred_cmd = '0;
		pred_len = '0;
		pred_rx_crc = '0;
		pred_len_err = 1'b0;
	endtask

	// Advance the predictor by one accepted beat and queue whatever result it owes.
	task automatic predict_beat(input logic [7:0] b, input logic last);
		int unsigned   p;
		logic [16:0]   cnt;
		logic          in_payload;
		frame_result_t r;
		p = 32'(pred_pos);
		in_payload = 1'b0;
		if (p < 4) begin
			// Header bytes: command first, then length, both big-endian.
			if (p < 2)
				pred_cmd = {pred_cmd[7:0], b};
			else
				pred_len = {pred_len[7:0], b};
			pred_crc = crc_step(pred_crc, b);
			if (p == 3)
				pred_len_err = (pred_len > pred_max);
		end else if (p < 32'(pred_len) + 4) begin
			pred_crc = crc_step(pred_crc, b);
			in_payload = 1'b1;
		end else begin
			// Trailer and anything after it just shift through the received CRC.
			pred_rx_crc = {pred_rx_crc[7:0], b};
		end
		cnt = (pred_pos == POS_MAX) ? POS_MAX : pred_pos + 17'd1;
		pred_pos = cnt;
		if (last) begin
			r.is_verdict = 1'b1;
			r.payload_byte = '0;
			r.frame_command = pred_cmd;
			r.frame_length = pred_len;
			if (cnt < HDR_BYTES) begin
				r.verdict = VERD_SHORT;
				r.frame_command = '0;
				r.frame_length = '0;
			end else if (pred_len_err) begin
				r.verdict = VERD_LEN;
			end else if (32'(cnt) != 32'(pred_len) + 6) begin
				r.verdict = VERD_COUNT;
			end else if (pred_rx_crc != pred_crc) begin
				r.verdict = VERD_CRC;
			end else begin
				r.verdict = VERD_OK;
			end
			expected_results.push_back(r);
			clear_prediction();
		end else if (in_payload && !pred_len_err) begin
			r.is_verdict = 1'b0;
			r.payload_byte = b;
			r.frame_command = pred_cmd;
			r.frame_length = pred_len;
			r.verdict = VERD_OK;
			expected_results.push_back(r);
		end
	endtask

	// Input driver. A stalled beat is held untouched; otherwise the next pending beat
	// is offered unless the phase's idle rate says to leave a gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
			end_of_transfer <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_beat(rx_byte, end_of_transfer);
				beats_to_send.delete(0);
			end
			if (in_valid && in_stall) begin
				// Beat not taken yet: keep valid and payload as they are.
			end else if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte <= beats_to_send[0].data;
				end_of_transfer <= beats_to_send[0].last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor and stall generator. Each accepted beat is checked field by
	// field against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		frame_result_t got;
		frame_result_t want;
		logic          stall_next;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.is_verdict = is_verdict;
				got.payload_byte = payload_byte;
				got.frame_command = frame_command;
				got.frame_length = frame_length;
				got.verdict = verdict_t'(verdict);
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected result v=%0d byte=%02h cmd=%04h len=%04h verd=%0d",
							got.is_verdict, got.payload_byte, got.frame_command,
							got.frame_length, got.verdict);
				end else begin
					want = expected_results.pop_front();
					if (got.is_verdict !== want.is_verdict
							|| got.payload_byte !== want.payload_byte
							|| got.frame_command !== want.frame_command
							|| got.frame_length !== want.frame_length
							|| got.verdict !== want.verdict) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: result mismatch exp v=%0d byte=%02h cmd=%04h len=%04h verd=%0d, got v=%0d byte=%02h cmd=%04h len=%04h verd=%0d",
								want.is_verdict, want.payload_byte, want.frame_command,
								want.frame_length, want.verdict,
								got.is_verdict, got.payload_byte, got.frame_command,
								got.frame_length, got.verdict);
					end
				end
			end
			// A pending hold-off request starts a long stall counted here.
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				stall_next = ($urandom_range(99) < recv_stall_pct);
			end
			out_stall <= stall_next;
		end
	end

	// Watchdog: abandon the run when no beat has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// APB write: setup cycle, then access cycle completing when pready is high.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_index_t'(addr[2]) == REG_MAX_PAYLOAD)
			pred_max = data[15:0];
	endtask

	task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_max_readback();
		logic [31:0] rd;
		apb_read(ADDR_MAX_PAYLOAD, rd);
		if (rd[15:0] !== pred_max) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: max_payload readback exp %04h got %04h", pred_max, rd[15:0]);
		end
	endtask

	// The upper data bits are random; only the low 16 belong to the register.
	task automatic set_max_payload(input logic [15:0] value);
		apb_write(ADDR_MAX_PAYLOAD, {16'($urandom), value});
		check_max_readback();
	endtask

	// Wait until every queued beat went in and every predicted result came out,
	// then let a few more cycles pass for beats that produce nothing.
	task automatic wait_drained();
		while (beats_to_send.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD)
			@(posedge clk);
	endtask

	// Build one transfer and queue its beats. The meaning of extra depends on the
	// kind (byte count for short, noise and trailing bytes, bytes kept for a cut
	// frame, bytes after the header of an over-long frame); negative picks at random.
	task automatic queue_frame(input frame_kind_t kind, input int unsigned plen,
			input logic [15:0] cmd, input int extra);
		logic [7:0]  fb[$];
		logic [15:0] c;
		int unsigned keep;
		int unsigned n;
		logic        header_only;
		c = '0;
		header_only = (kind == FR_LONG) && (plen > 32);
		fb.push_back(cmd[15:8]);
		fb.push_back(cmd[7:0]);
		fb.push_back(plen[15:8]);
		fb.push_back(plen[7:0]);
		if (!header_only)
			for (int unsigned i = 0; i < plen; i++)
				fb.push_back(8'($urandom));
		foreach (fb[i])
			c = crc_step(c, fb[i]);
		if (!header_only) begin
			fb.push_back(c[15:8]);
			fb.push_back(c[7:0]);
		end
		case (kind)
			FR_BAD_CRC: begin
				n = fb.size() - 1 - $urandom_range(1, 0);
				fb[n] = fb[n] ^ 8'(1 << $urandom_range(7, 0));
			end
			FR_TRUNC: begin
				keep = (extra < 0) ? $urandom_range(fb.size() - 1, 1) : extra;
				while (fb.size() > keep)
					void'(fb.pop_back());
			end
			FR_EXTRA: begin
				n = (extra < 0) ? $urandom_range(3, 1) : extra;
				repeat (n)
					fb.push_back(8'($urandom));
			end
			FR_SHORT, FR_NOISE: begin
				fb.delete();
				if (extra >= 0)
					n = extra;
				else
					n = (kind == FR_SHORT) ? $urandom_range(3, 1) : $urandom_range(16, 1);
				repeat (n)
					fb.push_back(8'($urandom));
			end
			FR_LONG: begin
				if (header_only) begin
					n = (extra < 0) ? $urandom_range(6, 0) : extra;
					repeat (n)
						fb.push_back(8'($urandom));
				end
			end
			default: begin
			end
		endcase
		foreach (fb[i])
			beats_to_send.push_back('{fb[i], (i == fb.size() - 1)});
		beats_queued += fb.size();
	endtask

	// Random traffic: mostly well-formed frames with random content, the rest
	// corrupted, cut, padded, over-long, short or plain noise.
	task automatic queue_random(input int unsigned n_beats);
		int unsigned start;
		int unsigned r;
		int unsigned plen;
		frame_kind_t kind;
		start = beats_queued;
		while (beats_queued - start < n_beats) begin
			r = $urandom_range(99, 0);
			plen = $urandom_range(12, 0);
			if (r < 55)
				kind = FR_GOOD;
			else if (r < 65)
				kind = FR_BAD_CRC;
			else if (r < 73)
				kind = FR_TRUNC;
			else if (r < 80)
				kind = FR_EXTRA;
			else if (r < 85)
				kind = FR_SHORT;
			else if (r < 92)
				kind = FR_LONG;
			else
				kind = FR_NOISE;
			if (kind == FR_LONG) begin
				if (pred_max == 16'hFFFF) begin
					kind = FR_GOOD;
				end else begin
					plen = 32'(pred_max) + $urandom_range(3, 1);
					if (plen > 32'hFFFF)
						plen = 32'hFFFF;
				end
			end
			queue_frame(kind, plen, 16'($urandom), -1);
		end
	endtask

	// One random phase: set the limit while idle, run half the traffic, let the
	// sender pause until everything has come out, then run the other half.
	task automatic run_phase(input int send_pct, input int recv_pct,
			input logic [15:0] max_len, input int unsigned n_beats, input logic long_hold);
		set_max_payload(max_len);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (long_hold)
			hold_req++;
		queue_random(n_beats / 2);
		wait_drained();
		queue_random(n_beats - n_beats / 2);
		wait_drained();
	endtask

	initial begin
		pred_max = MAX_PAYLOAD_RST;
		clear_prediction();
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The limit must come up at its reset value.
		check_max_readback();

		// Directed frames at the reset limit, no idling.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_frame(FR_SHORT, 0, 16'h0000, 1);
		queue_frame(FR_SHORT, 0, 16'h0000, 2);
		queue_frame(FR_GOOD, 0, 16'hFFFF, -1);
		queue_frame(FR_BAD_CRC, 0, 16'h0000, -1);
		// Header claims 0xFFFF bytes, over the limit; transfer ends with the header.
		queue_frame(FR_LONG, 32'hFFFF, 16'h8001, 0);
		// Final byte lands inside the payload: verdict only, no payload result.
		queue_frame(FR_TRUNC, 1, 16'h7FFE, 5);
		// A byte past the trailer turns a good frame into a count mismatch.
		queue_frame(FR_EXTRA, 0, 16'h5AA5, 1);
		wait_drained();

		// A write to the unused index must leave the limit alone.
		apb_write(ADDR_UNUSED, $urandom);
		check_max_readback();

		// Largest limit, then a padded frame and a clean one.
		set_max_payload(16'hFFFF);
		queue_frame(FR_EXTRA, 12, 16'($urandom), 2);
		queue_frame(FR_GOOD, 12, 16'($urandom), -1);
		wait_drained();

		// Random phases over several limits, the extremes among them. The first and
		// third also hold the receiver off long enough to back the input up.
		run_phase(0, 0, MAX_PAYLOAD_RST, 140, 1'b1);
		run_phase(61, 0, 16'h0000, 140, 1'b0);
		run_phase(0, 61, 16'd16, 140, 1'b1);
		run_phase(22, 22, 16'hFFFF, 140, 1'b0);
		run_phase(0, 0, 16'($urandom_range(30, 1)), 140, 1'b0);

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
